// ===== hdl/quaternion_to_euler_core_assert.svh =====
// Assertion macros shared by the quaternion to Euler core.
`ifndef QUATERNION_TO_EULER_CORE_ASSERT_SVH
`define QUATERNION_TO_EULER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define QTE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("quaternion_to_euler_core: assertion failed");
// Next-cycle implication.
`define QTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("quaternion_to_euler_core: assertion failed");
`else
`define QTE_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define QTE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/qte_pkg.sv =====
package qte_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_LEN      = 24;
  localparam int NUM_ITER      = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

  // term width (Q28 sine/cosine terms), CORDIC datapath, angle accumulator
  localparam int TW       = 34;
  localparam int CW       = 37;
  localparam int AW       = 34;
  localparam int ANG_W    = AW - 16;
  localparam int ROOT_W   = 29;
  localparam int REM_W    = 57;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int SQ_RW    = 34;

  localparam logic signed [TW-1:0] ONE_Q28 = TW'(64'sd268435456);
  localparam logic signed [AW-1:0] PI_ACC  = AW'(64'sd2147483648);
  localparam logic signed [ANG_W-1:0] HALF_PI_OUT = ANG_W'(16384);

  typedef struct packed {
    logic signed [TW-1:0] sr;
    logic signed [TW-1:0] cr;
    logic signed [TW-1:0] sp;
    logic signed [TW-1:0] sy;
    logic signed [TW-1:0] cy;
    logic                 clamp;
  } terms_t;

  localparam logic [29:0] ATAN_TAB [ATAN_LEN] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10680862, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163, 30'd81
  };

endpackage

// ===== hdl/qte_terms.sv =====
module qte_terms
  import qte_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              valid_i,
  input  logic [63:0]       quat_i,
  output logic              valid_o,
  output terms_t            terms_o,
  output logic [REM_W-1:0]  rem_o
);

  logic [3:0] v_r;

  logic signed [15:0] w_r, x_r, y_r, z_r;
  logic signed [31:0] wx_r, yz_r, wy_r, zx_r, wz_r, xy_r, xx_r, yy_r, zz_r;
  terms_t             t3_r, t4_r;
  logic [ROOT_W-1:0]  mag_r;
  logic [REM_W-1:0]   rem_r;

  logic signed [32:0] s_r, c_r, s_p, s_y, c_y;
  logic signed [TW-1:0] sp_nxt;
  logic [TW-1:0]      mag_full;
  logic               clamp_nxt;
  logic [2*ROOT_W-1:0] sq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], valid_i};
    end
  end

  always_comb begin
    s_r = 33'(wx_r) + 33'(yz_r);
    c_r = 33'(xx_r) + 33'(yy_r);
    s_p = 33'(wy_r) - 33'(zx_r);
    s_y = 33'(wz_r) + 33'(xy_r);
    c_y = 33'(yy_r) + 33'(zz_r);
    sp_nxt = $signed({s_p, 1'b0});
    mag_full = sp_nxt[TW-1] ? TW'(-sp_nxt) : TW'(sp_nxt);
    clamp_nxt = mag_full > TW'(ONE_Q28);
    sq = {{ROOT_W{1'b0}}, mag_r} * {{ROOT_W{1'b0}}, mag_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r  <= quat_i[15:0];
      x_r  <= quat_i[31:16];
      y_r  <= quat_i[47:32];
      z_r  <= quat_i[63:48];
      wx_r <= w_r * x_r;
      yz_r <= y_r * z_r;
      wy_r <= w_r * y_r;
      zx_r <= z_r * x_r;
      wz_r <= w_r * z_r;
      xy_r <= x_r * y_r;
      xx_r <= x_r * x_r;
      yy_r <= y_r * y_r;
      zz_r <= z_r * z_r;
      t3_r.sr    <= $signed({s_r, 1'b0});
      t3_r.cr    <= ONE_Q28 - $signed({c_r, 1'b0});
      t3_r.sp    <= sp_nxt;
      t3_r.sy    <= $signed({s_y, 1'b0});
      t3_r.cy    <= ONE_Q28 - $signed({c_y, 1'b0});
      t3_r.clamp <= clamp_nxt;
      mag_r      <= clamp_nxt ? '0 : mag_full[ROOT_W-1:0];
      t4_r  <= t3_r;
      // 2^56 minus the square; the square never exceeds 2^56 here
      rem_r <= {1'b1, {(REM_W-1){1'b0}}} - sq[REM_W-1:0];
    end
  end

  assign valid_o = v_r[3];
  assign terms_o = t4_r;
  assign rem_o   = rem_r;

endmodule

// ===== hdl/qte_sqrt.sv =====
module qte_sqrt
  import qte_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              valid_i,
  input  logic [REM_W-1:0]  rem_i,
  input  terms_t            terms_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output terms_t            terms_o
);

  logic [ROOT_W-1:0] v_r;
  logic [SQ_RW-1:0]  r_r    [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [RAD_W-1:0]  rad_r  [ROOT_W];
  terms_t            pay_r  [ROOT_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[ROOT_W-2:0], valid_i};
    end
  end

  // one root bit per stage, restoring digit recurrence
  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic [SQ_RW-1:0]  r_in, rr, t;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rad_in;
    terms_t            pay_in;
    logic              ge;

    if (k == 0) begin : g_first
      assign r_in    = '0;
      assign root_in = '0;
      assign rad_in  = {1'b0, rem_i};
      assign pay_in  = terms_i;
    end else begin : g_next
      assign r_in    = r_r[k-1];
      assign root_in = root_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign pay_in  = pay_r[k-1];
    end

    always_comb begin
      rr = {r_in[SQ_RW-3:0], rad_in[RAD_W-1:RAD_W-2]};
      t  = {{(SQ_RW-ROOT_W-2){1'b0}}, root_in, 2'b01};
      ge = rr >= t;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k]    <= ge ? rr - t : rr;
        root_r[k] <= {root_in[ROOT_W-2:0], ge};
        rad_r[k]  <= {rad_in[RAD_W-3:0], 2'b00};
        pay_r[k]  <= pay_in;
      end
    end
  end

  assign valid_o = v_r[ROOT_W-1];
  assign root_o  = root_r[ROOT_W-1];
  assign terms_o = pay_r[ROOT_W-1];

endmodule

// ===== hdl/qte_cordic.sv =====
module qte_cordic
  import qte_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [TW-1:0]    y_i,
  input  logic signed [TW-1:0]    x_i,
  output logic signed [ANG_W-1:0] angle_o
);

  logic signed [CW-1:0] x_r    [NUM_ITER+1];
  logic signed [CW-1:0] y_r    [NUM_ITER+1];
  logic signed [AW-1:0] acc_r  [NUM_ITER+1];
  logic                 zero_r [NUM_ITER+1];

  logic signed [CW-1:0] xe, ye;
  logic                 neg;
  logic signed [AW-1:0] acc_f, acc_rnd;

  // quadrant fold: move a negative cosine into the right half plane
  always_comb begin
    xe  = CW'(x_i);
    ye  = CW'(y_i);
    neg = x_i[TW-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= neg ? -xe : xe;
      y_r[0]    <= neg ? -ye : ye;
      acc_r[0]  <= !neg ? '0 : (y_i[TW-1] ? -PI_ACC : PI_ACC);
      zero_r[0] <= (x_i == '0) && (y_i == '0);
    end
  end

  for (genvar i = 0; i < NUM_ITER; i++) begin : g_iter
    logic signed [CW-1:0] xs, ys;
    logic signed [AW-1:0] ang;
    logic                 up;

    always_comb begin
      xs  = x_r[i] >>> i;
      ys  = y_r[i] >>> i;
      ang = $signed({{(AW-30){1'b0}}, ATAN_TAB[i]});
      up  = !y_r[i][CW-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1]    <= up ? x_r[i] + ys : x_r[i] - ys;
        y_r[i+1]    <= up ? y_r[i] - xs : y_r[i] + xs;
        acc_r[i+1]  <= up ? acc_r[i] + ang : acc_r[i] - ang;
        zero_r[i+1] <= zero_r[i];
      end
    end
  end

  // round half up to 16 fraction bits dropped
  always_comb begin
    acc_f   = zero_r[NUM_ITER] ? '0 : acc_r[NUM_ITER];
    acc_rnd = acc_f + AW'(32768);
  end

  assign angle_o = acc_rnd[AW-1:16];

endmodule

// ===== hdl/quaternion_to_euler_core.sv =====
// Channel   Dir  Payload
// in_*      in   tdata: quat_w, quat_x, quat_y, quat_z (16 bits each, low first)
// out_*     out  tdata: roll_angle, pitch_angle, yaw_angle; tuser: pitch_clamped
//
// One quaternion per cycle is accepted while the output is not stalled;
// each gives one result. The pipeline holds product/sum stages, one square
// root bit per stage, fold plus one CORDIC rotation per stage, and an output register.
// Reset clears only the valid bits; the datapath carries no reset.
// A stall at the output freezes the whole pipeline; nothing is dropped.
`include "quaternion_to_euler_core_assert.svh"

module quaternion_to_euler_core
  import qte_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // roll_angle, pitch_angle, yaw_angle
  output logic        out_tuser   // pitch_clamped
);

  localparam int CL = NUM_ITER + 1;

  logic              en;
  logic              t_valid, s_valid;
  terms_t            t_terms, s_terms;
  logic [REM_W-1:0]  t_rem;
  logic [ROOT_W-1:0] s_root;

  logic signed [ANG_W-1:0] roll_a, pitch_a, yaw_a, pitch_sat;

  logic [CL-1:0] cv_r, clamp_r, neg_r;

  logic        out_tvalid_r;
  logic [47:0] out_tdata_r;
  logic        out_tuser_r;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  qte_terms u_terms (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (in_tvalid),
    .quat_i  (in_tdata),
    .valid_o (t_valid),
    .terms_o (t_terms),
    .rem_o   (t_rem)
  );

  qte_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (t_valid),
    .rem_i   (t_rem),
    .terms_i (t_terms),
    .valid_o (s_valid),
    .root_o  (s_root),
    .terms_o (s_terms)
  );

  qte_cordic u_roll (
    .clk     (clk),
    .en      (en),
    .y_i     (s_terms.sr),
    .x_i     (s_terms.cr),
    .angle_o (roll_a)
  );

  qte_cordic u_pitch (
    .clk     (clk),
    .en      (en),
    .y_i     (s_terms.sp),
    .x_i     ($signed({{(TW-ROOT_W){1'b0}}, s_root})),
    .angle_o (pitch_a)
  );

  qte_cordic u_yaw (
    .clk     (clk),
    .en      (en),
    .y_i     (s_terms.sy),
    .x_i     (s_terms.cy),
    .angle_o (yaw_a)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r <= '0;
    end else if (en) begin
      cv_r <= {cv_r[CL-2:0], s_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      clamp_r <= {clamp_r[CL-2:0], s_terms.clamp};
      neg_r   <= {neg_r[CL-2:0], s_terms.sp[TW-1]};
    end
  end

  // clamp beyond one, then saturate any CORDIC overshoot
  always_comb begin
    if (clamp_r[CL-1]) begin
      pitch_sat = neg_r[CL-1] ? -HALF_PI_OUT : HALF_PI_OUT;
    end else if (pitch_a > HALF_PI_OUT) begin
      pitch_sat = HALF_PI_OUT;
    end else if (pitch_a < -HALF_PI_OUT) begin
      pitch_sat = -HALF_PI_OUT;
    end else begin
      pitch_sat = pitch_a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= cv_r[CL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= {yaw_a[15:0], pitch_sat[15:0], roll_a[15:0]};
      out_tuser_r <= clamp_r[CL-1];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  `QTE_ASSERT_SAME(a_clamp_limit, clk, rst_n, out_tvalid && out_tuser,
                   out_tdata[31:16] == 16'h4000 || out_tdata[31:16] == 16'hC000)
  `QTE_ASSERT_SAME(a_pitch_range, clk, rst_n, out_tvalid,
                   $signed(out_tdata[31:16]) <= 16'sd16384 &&
                   $signed(out_tdata[31:16]) >= -16'sd16384)
  `QTE_ASSERT_SAME(a_stall_holds_input, clk, rst_n, out_tvalid && !out_tready, !in_tready)

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        clamped;
    logic [15:0] yaw;
    logic [15:0] pitch;
    logic [15:0] roll;
  } euler_t;

  localparam longint Q28_ONE = 64'sd268435456;
  localparam int     PITCH_LIM = 16384;
  localparam int     LATENCY = 4 + 29 + qte_pkg::NUM_ITER + 2;
  localparam int     N_RANDOM = 1310;

  class euler_scoreboard;
    euler_t pending[$];
    int     errors;

    static function longint shr_floor(longint v, int s);
      return v >>> s;
    endfunction

    static function longint root_floor(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return longint'(res);
    endfunction

    static function longint vector_angle(longint ys, longint xs);
      longint acc, xt, yt;
      acc = 0;
      if (xs == 0 && ys == 0) return 0;
      if (xs < 0) begin
        acc = (ys >= 0) ? (64'sd1 <<< 31) : -(64'sd1 <<< 31);
        xs = -xs;
        ys = -ys;
      end
      for (int i = 0; i < qte_pkg::NUM_ITER; i++) begin
        xt = shr_floor(xs, i);
        yt = shr_floor(ys, i);
        if (ys >= 0) begin
          xs = xs + yt; ys = ys - xt; acc += longint'(qte_pkg::ATAN_TAB[i]);
        end else begin
          xs = xs - yt; ys = ys + xt; acc -= longint'(qte_pkg::ATAN_TAB[i]);
        end
      end
      return shr_floor(acc + 32768, 16);
    endfunction

    function void note_quat(logic [63:0] q);
      longint w, x, y, z, sr, cr, sp, sy, cy, mag, p;
      euler_t e;
      w = longint'($signed(q[15:0]));
      x = longint'($signed(q[31:16]));
      y = longint'($signed(q[47:32]));
      z = longint'($signed(q[63:48]));
      sr = 2 * (w * x + y * z);
      cr = Q28_ONE - 2 * (x * x + y * y);
      sp = 2 * (w * y - z * x);
      sy = 2 * (w * z + x * y);
      cy = Q28_ONE - 2 * (y * y + z * z);
      e.roll = 16'(vector_angle(sr, cr));
      e.yaw = 16'(vector_angle(sy, cy));
      mag = (sp < 0) ? -sp : sp;
      if (mag > Q28_ONE) begin
        p = (sp < 0) ? -PITCH_LIM : PITCH_LIM;
        e.clamped = 1'b1;
      end else begin
        p = vector_angle(sp, root_floor((64'd1 << 56) - longint'(mag) * longint'(mag)));
        if (p > PITCH_LIM) p = PITCH_LIM;
        if (p < -PITCH_LIM) p = -PITCH_LIM;
        e.clamped = 1'b0;
      end
      e.pitch = 16'(p);
      pending.push_back(e);
    endfunction

    function void check_euler(logic [47:0] d, logic u);
      euler_t e;
      if (pending.size() == 0) begin
        $error("unexpected result roll=%0h pitch=%0h yaw=%0h", d[15:0], d[31:16], d[47:32]);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[15:0] !== e.roll) begin
        $error("roll_angle: expected %0d actual %0d", $signed(e.roll), $signed(d[15:0]));
        errors++;
      end
      if (d[31:16] !== e.pitch) begin
        $error("pitch_angle: expected %0d actual %0d", $signed(e.pitch), $signed(d[31:16]));
        errors++;
      end
      if (d[47:32] !== e.yaw) begin
        $error("yaw_angle: expected %0d actual %0d", $signed(e.yaw), $signed(d[47:32]));
        errors++;
      end
      if (u !== e.clamped) begin
        $error("pitch_clamped: expected %0b actual %0b", e.clamped, u);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tuser;

  euler_scoreboard sb = new();
  bit hold_sink = 1'b0;

  quaternion_to_euler_core u_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_quat(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_euler(out_tdata, out_tuser);
  end

  // sink: random stalls, with one long hold-off on request
  initial begin
    int g;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_sink) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_sink = 1'b0;
      end
      g = gap_len();
      if (g > 0) begin
        out_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_quat(logic [15:0] w, x, y, z, bit no_gap);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {z, y, x, w};
    @(posedge clk iff in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk iff sb.pending.size() == 0);
  endtask

  function automatic logic [15:0] rnd_comp(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 32768)) - 16384);
      default: return 16'($signed($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  initial begin
    logic [15:0] w, x, y, z;
    real a, b, c, d, n;
    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: identity, axes, field extremes, pi wraps, gimbal lock, zero terms
    send_quat(16'd16384, 0, 0, 0, 1'b0);
    send_quat(0, 16'd16384, 0, 0, 1'b0);
    send_quat(0, 0, 16'd16384, 0, 1'b0);
    send_quat(0, 0, 0, 16'd16384, 1'b0);
    send_quat(16'd11585, 0, 16'd11585, 0, 1'b0);
    send_quat(16'd11585, 0, -16'sd11585, 0, 1'b0);
    send_quat(16'd11586, 0, 16'd11586, 0, 1'b0);
    send_quat(16'd11586, 0, -16'sd11586, 0, 1'b0);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
    send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
    send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1'b0);
    send_quat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 1'b0);
    send_quat(0, 0, 0, 0, 1'b0);
    send_quat(16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b0);
    send_quat(16'd11585, 16'd11585, 0, 0, 1'b0);
    send_quat(16'd11585, -16'sd11585, 0, 0, 1'b0);
    send_quat(16'd8192, 16'd8192, 16'd8192, 16'd8192, 1'b0);
    send_quat(16'd8192, -16'sd8192, 16'd8192, -16'sd8192, 1'b0);
    send_quat(0, 16'd11585, 0, 16'd11585, 1'b0);
    send_quat(16'd16384, 16'd1, 0, 0, 1'b0);
    drain();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 400) begin
        // stall the sink while the source streams
        hold_sink = 1'b1;
        for (int k = 0; k < 120; k++)
          send_quat(rnd_comp(0), rnd_comp(1), rnd_comp(0), rnd_comp(1), 1'b1);
      end
      if (i == 900) drain();
      if ($urandom_range(0, 3) != 0) begin
        // near-unit quaternion from random direction
        a = $itor($signed(16'($urandom))); b = $itor($signed(16'($urandom)));
        c = $itor($signed(16'($urandom))); d = $itor($signed(16'($urandom)));
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0) n = 1.0;
        w = 16'($rtoi(a * 16384.0 / n)); x = 16'($rtoi(b * 16384.0 / n));
        y = 16'($rtoi(c * 16384.0 / n)); z = 16'($rtoi(d * 16384.0 / n));
        send_quat(w, x, y, z, 1'b0);
      end else begin
        send_quat(rnd_comp($urandom_range(0, 2)), rnd_comp($urandom_range(0, 2)),
                  rnd_comp($urandom_range(0, 2)), rnd_comp($urandom_range(0, 2)), 1'b0);
      end
    end
    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("** quaternion_to_euler_core: PASSED **");
    end else begin
      $display("** quaternion_to_euler_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("** quaternion_to_euler_core: FAILED **");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/qte_pkg.sv
hdl/qte_terms.sv
hdl/qte_sqrt.sv
hdl/qte_cordic.sv
hdl/quaternion_to_euler_core.sv
tb/tb.sv
